// File: sv/twas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package twas_pkg;

    // store and coordinate geometry
    localparam int TEXEL_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(TEXEL_DEPTH);
    localparam int MAX_DIM     = 1024;
    localparam int FRAC_BITS   = 16;
    localparam int COORD_W     = 32;
    localparam int SIZE_W      = 11;
    localparam int IDX_W       = 10;
    localparam int TEXEL_W     = 64;
    localparam int OPND_W      = COORD_W - 1;
    localparam int PROD_W      = OPND_W + SIZE_W - FRAC_BITS;
    localparam int OFFSET_W    = IDX_W + SIZE_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SIZE_W;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_MODE  = 2'd2;

    // wrap modes, code three behaves as clamp
    localparam logic [1:0] WRAP_REPEAT = 2'd0;
    localparam logic [1:0] WRAP_MIRROR = 2'd1;
    localparam logic [1:0] WRAP_CLAMP  = 2'd2;

    typedef enum logic [1:0] {
        FUNC_WRITE  = 2'd0,
        FUNC_SAMPLE = 2'd1,
        FUNC_FETCH  = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    // size register saturated into one to max_dim
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        r = s;
        if (s == '0)
        begin
            r = SIZE_W'(1);
        end
        else if (s > SIZE_W'(MAX_DIM))
        begin
            r = SIZE_W'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/twas_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface twas_req_if
    import twas_pkg::*;
    ;
    logic                      valid;
    logic                      ready;
    func_t                     func;
    logic signed [COORD_W-1:0] u;
    logic signed [COORD_W-1:0] v;
    logic [IDX_W-1:0]          pixel_x;
    logic [IDX_W-1:0]          pixel_y;
    logic [TEXEL_W-1:0]        texel_in;

    modport source (output valid, func, u, v, pixel_x, pixel_y, texel_in, input ready);
    modport sink (input valid, func, u, v, pixel_x, pixel_y, texel_in, output ready);
endinterface

interface twas_rsp_if
    import twas_pkg::*;
    ;
    logic               valid;
    logic               ready;
    logic [TEXEL_W-1:0] texel_out;
    logic [IDX_W-1:0]   texel_x;
    logic [IDX_W-1:0]   texel_y;
    logic               out_of_range;

    modport source (output valid, texel_out, texel_x, texel_y, out_of_range, input ready);
    modport sink (input valid, texel_out, texel_x, texel_y, out_of_range, output ready);
endinterface

`default_nettype wire

// File: sv/twas_axis.sv
`timescale 1ns / 1ps
`default_nettype none

module twas_axis
    import twas_pkg::*;
(
    input  wire logic                clk,
    input  wire stage_en_t           en,
    input  wire logic [COORD_W-1:0]  coord,
    input  wire logic [SIZE_W-1:0]   size,
    input  wire logic [1:0]          mode,
    input  wire logic                use_pixel,
    input  wire logic [IDX_W-1:0]    pixel,
    output logic [IDX_W-1:0]         index
);

    localparam logic [OPND_W-1:0] ONE = OPND_W'(1) << FRAC_BITS;

    logic [OPND_W-1:0]        frac_ext;
    logic                     odd;
    logic [OPND_W-1:0]        opnd_next;
    logic [OPND_W-1:0]        opnd_reg;
    logic [OPND_W+SIZE_W-1:0] full;
    logic [PROD_W-1:0]        prod_next;
    logic [PROD_W-1:0]        prod_reg;
    logic [SIZE_W-1:0]        lim;
    logic [IDX_W-1:0]         index_next;
    logic [IDX_W-1:0]         index_reg;

    // stage one: pick the multiplier operand per wrap mode
    always_comb
    begin
        frac_ext = {{(OPND_W-FRAC_BITS){1'b0}}, coord[FRAC_BITS-1:0]};
        odd      = coord[FRAC_BITS];
        unique case (mode)
            WRAP_REPEAT: opnd_next = frac_ext;
            WRAP_MIRROR: opnd_next = odd ? (ONE - frac_ext) : frac_ext;
            default:     opnd_next = coord[COORD_W-1] ? '0 : coord[OPND_W-1:0];
        endcase
    end

    // stage two: scale by size
    always_comb
    begin
        full      = {{SIZE_W{1'b0}}, opnd_reg} * {{OPND_W{1'b0}}, size};
        prod_next = full[OPND_W+SIZE_W-1:FRAC_BITS];
    end

    // stage three: clamp to size-1, or take the pixel for direct access
    always_comb
    begin
        lim = size - SIZE_W'(1);
        if (use_pixel)
        begin
            index_next = pixel;
        end
        else if (prod_reg > PROD_W'(lim))
        begin
            index_next = lim[IDX_W-1:0];
        end
        else
        begin
            index_next = prod_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            opnd_reg <= opnd_next;
        end
        if (en.s2)
        begin
            prod_reg <= prod_next;
        end
        if (en.s3)
        begin
            index_reg <= index_next;
        end
    end

    assign index = index_reg;

endmodule

`default_nettype wire

// File: sv/texture_wrap_address_sampler_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel | dir  | handshake    | payload
// --------+------+--------------+---------------------------------------------------
// req     | in   | valid/ready  | func, u, v, pixel_x, pixel_y, texel_in
// rsp     | out  | valid/ready  | texel_out, texel_x, texel_y, out_of_range
// cfg     | in   | cfg_we       | cfg_index, cfg_data (tex_width, tex_height, wrap_mode)
//
// one word accepted per cycle while req.ready is high; a sample or fetch answers from the last stage
// five register stages: operand select, size multiply, clamp, offset multiply-add,
// store read with registered data; the single store port sets the one-word-per-cycle rate
// each stage holds its own valid bit, so bubbles close up while rsp is stalled and
// req.ready only falls once every stage is full
// reset clears the valid bits, sets the size registers to one and the wrap mode to repeat; the store is not cleared

module texture_wrap_address_sampler_top
    import twas_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    twas_req_if.sink                   req,
    twas_rsp_if.source                 rsp
);

    // configuration
    logic [SIZE_W-1:0] tex_width_reg;
    logic [SIZE_W-1:0] tex_height_reg;
    logic [1:0]        wrap_mode_reg;
    logic [SIZE_W-1:0] w_eff;
    logic [SIZE_W-1:0] h_eff;

    // stage enables, a stage moves when it is empty or the next one moves
    logic      en1, en2, en3, en4, en5;
    stage_en_t axis_en;

    // valid bits
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic s5_valid_next;

    // payload carried alongside the axis units
    func_t              s1_func_reg, s2_func_reg, s3_func_reg, s4_func_reg;
    logic [IDX_W-1:0]   s1_px_reg, s1_py_reg, s2_px_reg, s2_py_reg;
    logic [TEXEL_W-1:0] s1_data_reg, s2_data_reg, s3_data_reg, s4_data_reg;
    logic               s3_pix_bad_next, s3_pix_bad_reg;
    logic               s2_use_pixel;
    logic [IDX_W-1:0]   tx3, ty3;

    // offset stage
    logic [OFFSET_W-1:0] offset_next;
    logic                s4_bad_next;
    logic [ADDR_W-1:0]   s4_addr_reg;
    logic                s4_bad_reg;
    logic [IDX_W-1:0]    s4_tx_reg, s4_ty_reg;

    // store and output stage
    logic [TEXEL_W-1:0] texel_mem [TEXEL_DEPTH];
    logic               mem_we;
    logic [TEXEL_W-1:0] s5_rd_data_reg;
    logic [IDX_W-1:0]   s5_tx_reg, s5_ty_reg;
    logic               s5_bad_reg;

    // configuration writes, only while the block is idle: the user must keep to this, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg  <= SIZE_W'(1);
            tex_height_reg <= SIZE_W'(1);
            wrap_mode_reg  <= WRAP_REPEAT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TEX_WIDTH:  tex_width_reg  <= cfg_data;
                REG_TEX_HEIGHT: tex_height_reg <= cfg_data;
                REG_WRAP_MODE:  wrap_mode_reg  <= cfg_data[1:0];
                default:        ;
            endcase
        end
    end

    assign w_eff = eff_size(tex_width_reg);
    assign h_eff = eff_size(tex_height_reg);

    assign en5 = !s5_valid_reg || rsp.ready;
    assign en4 = !s4_valid_reg || en5;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;

    assign req.ready  = en1;
    assign axis_en.s1 = en1;
    assign axis_en.s2 = en2;
    assign axis_en.s3 = en3;

    // per-axis wrap, scale and clamp, stages one to three
    assign s2_use_pixel = (s2_func_reg != FUNC_SAMPLE);

    twas_axis u_axis_x (
        .clk       (clk),
        .en        (axis_en),
        .coord     (req.u),
        .size      (w_eff),
        .mode      (wrap_mode_reg),
        .use_pixel (s2_use_pixel),
        .pixel     (s2_px_reg),
        .index     (tx3)
    );

    twas_axis u_axis_y (
        .clk       (clk),
        .en        (axis_en),
        .coord     (req.v),
        .size      (h_eff),
        .mode      (wrap_mode_reg),
        .use_pixel (s2_use_pixel),
        .pixel     (s2_py_reg),
        .index     (ty3)
    );

    // pixel bounds test for every word that is not a sample (write, fetch and none)
    assign s3_pix_bad_next = s2_use_pixel &&
                             (({1'b0, s2_px_reg} >= w_eff) || ({1'b0, s2_py_reg} >= h_eff));

    // row-major offset, anything past the store is flagged
    assign offset_next = ({{(OFFSET_W-IDX_W){1'b0}}, ty3} * {{(OFFSET_W-SIZE_W){1'b0}}, w_eff})
                         + {{(OFFSET_W-IDX_W){1'b0}}, tx3};
    assign s4_bad_next = s3_pix_bad_reg || (offset_next >= OFFSET_W'(TEXEL_DEPTH));

    // writes retire here, samples and fetches move into the output stage
    assign mem_we        = en5 && s4_valid_reg && (s4_func_reg == FUNC_WRITE) && !s4_bad_reg;
    assign s5_valid_next = s4_valid_reg &&
                           ((s4_func_reg == FUNC_SAMPLE) || (s4_func_reg == FUNC_FETCH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= req.valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (en5)
            begin
                s5_valid_reg <= s5_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_func_reg <= req.func;
            s1_px_reg   <= req.pixel_x;
            s1_py_reg   <= req.pixel_y;
            s1_data_reg <= req.texel_in;
        end
        if (en2)
        begin
            s2_func_reg <= s1_func_reg;
            s2_px_reg   <= s1_px_reg;
            s2_py_reg   <= s1_py_reg;
            s2_data_reg <= s1_data_reg;
        end
        if (en3)
        begin
            s3_func_reg    <= s2_func_reg;
            s3_pix_bad_reg <= s3_pix_bad_next;
            s3_data_reg    <= s2_data_reg;
        end
        if (en4)
        begin
            s4_func_reg <= s3_func_reg;
            s4_addr_reg <= offset_next[ADDR_W-1:0];
            s4_bad_reg  <= s4_bad_next;
            s4_tx_reg   <= tx3;
            s4_ty_reg   <= ty3;
            s4_data_reg <= s3_data_reg;
        end
        if (en5)
        begin
            s5_tx_reg  <= s4_tx_reg;
            s5_ty_reg  <= s4_ty_reg;
            s5_bad_reg <= s4_bad_reg;
        end
    end

    // texel store, one write and one registered read per cycle, both at the stage-four address
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            texel_mem[s4_addr_reg] <= s4_data_reg;
        end
        if (en5)
        begin
            s5_rd_data_reg <= texel_mem[s4_addr_reg];
        end
    end

    assign rsp.valid        = s5_valid_reg;
    assign rsp.texel_out    = s5_bad_reg ? '0 : s5_rd_data_reg;
    assign rsp.texel_x      = s5_tx_reg;
    assign rsp.texel_y      = s5_ty_reg;
    assign rsp.out_of_range = s5_bad_reg;

    // input only backs up once every stage holds a word and the output is stalled
    a_full_before_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg
                        && s5_valid_reg && !rsp.ready))
        else $error("req stalled while a stage is empty");

    // resolved sample indices stay inside the texture
    a_sample_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && (s3_func_reg == FUNC_SAMPLE)) |->
            (({1'b0, tx3} < w_eff) && ({1'b0, ty3} < h_eff)))
        else $error("sample index outside texture");

    // a write word never turns into a result
    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (en5 && s4_valid_reg && (s4_func_reg == FUNC_WRITE)) |=> !s5_valid_reg)
        else $error("write produced a result");

    // a store write always carries an in-range offset
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (en4 && s3_valid_reg && (s3_func_reg == FUNC_WRITE) && !s4_bad_next) |->
            (offset_next < OFFSET_W'(TEXEL_DEPTH)))
        else $error("store write past its depth");

endmodule

`default_nettype wire
